FILE: rtl/line_pixel_generator_core_assert.svh
// ----------------------------------------------------------------------------
// Line pixel generator assertion macros
// Shared concurrent assertion forms for the line pixel generator RTL.
// ----------------------------------------------------------------------------
`ifndef LINE_PIXEL_GENERATOR_CORE_ASSERT_SVH
`define LINE_PIXEL_GENERATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LPG_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lpg: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define LPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lpg: next-cycle check failed");

`endif

FILE: rtl/lpg_pkg.sv
// ----------------------------------------------------------------------------
// Line pixel generator package
// Widths, command codes, controller states and control/status structs.
// ----------------------------------------------------------------------------
package lpg_pkg;

    localparam int COORD_BITS   = 10;
    localparam int FRAC_BITS    = 16;
    localparam int COLOR_BITS   = 16;
    localparam int DIV_BITS     = COORD_BITS + FRAC_BITS;
    localparam int ACC_BITS     = COORD_BITS + FRAC_BITS + 2;
    localparam int DIV_CNT_BITS = $clog2(DIV_BITS);

    localparam logic [FRAC_BITS-1:0]    HALF_ONE = FRAC_BITS'(1) << (FRAC_BITS - 1);
    localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(DIV_BITS - 1);

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_ACTIVE
    } t_lpg_state;

    typedef struct packed {
        logic load_line;
        logic step;
    } t_lpg_ctrl;

    typedef struct packed {
        logic div_done;
        logic last;
    } t_lpg_status;

endpackage

FILE: rtl/lpg_if.sv
// ----------------------------------------------------------------------------
// Line pixel generator stream interfaces
// Valid/ready channels for line commands and emitted pixels.
// ----------------------------------------------------------------------------
interface lpg_cmd_if;
    logic                            valid;
    logic                            ready;
    logic                            cmd;
    logic [lpg_pkg::COORD_BITS-1:0]  x_start;
    logic [lpg_pkg::COORD_BITS-1:0]  y_start;
    logic [lpg_pkg::COORD_BITS-1:0]  x_end;
    logic [lpg_pkg::COORD_BITS-1:0]  y_end;
    logic [lpg_pkg::COLOR_BITS-1:0]  line_color;

    modport source (output valid, cmd, x_start, y_start, x_end, y_end, line_color,
                    input ready);
    modport sink   (input valid, cmd, x_start, y_start, x_end, y_end, line_color,
                    output ready);
endinterface

interface lpg_pix_if;
    logic                            valid;
    logic                            ready;
    logic [lpg_pkg::COORD_BITS-1:0]  pixel_x;
    logic [lpg_pkg::COORD_BITS-1:0]  pixel_y;
    logic [lpg_pkg::COLOR_BITS-1:0]  pixel_color;
    logic                            last_pixel;

    modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel,
                    input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel,
                    output ready);
endinterface

FILE: rtl/line_pixel_generator_core.sv
// A start command (cmd 0) is taken and then holds off the command channel while
// a restoring divider forms the 10.16 slope one quotient bit per cycle
// (COORD_BITS + 16 bits) and the slope is loaded. Step commands (cmd 1) are
// taken one per cycle while the output register has room, each producing one
// pixel there, a line giving its longer delta plus one pixels with the last one
// flagged; steps with no line in progress are consumed without a pixel.
// ----------------------------------------------------------------------------
// Line pixel generator core
// EFLA line rasterizer with 12.16 fixed-point minor axis accumulation.
// ----------------------------------------------------------------------------
module line_pixel_generator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lpg_cmd_if.sink     i_cmd,
    lpg_pix_if.source   o_pix
);

    lpg_pkg::t_lpg_ctrl    ctrl;
    lpg_pkg::t_lpg_status  status;
    logic                  in_ready;
    logic                  out_valid;

    lpg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .i_in_cmd    (i_cmd.cmd),
        .i_out_ready (o_pix.ready),
        .i_status    (status),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_ctrl      (ctrl)
    );

    lpg_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .o_status      (status),
        .i_x_start     (i_cmd.x_start),
        .i_y_start     (i_cmd.y_start),
        .i_x_end       (i_cmd.x_end),
        .i_y_end       (i_cmd.y_end),
        .i_line_color  (i_cmd.line_color),
        .o_pixel_x     (o_pix.pixel_x),
        .o_pixel_y     (o_pix.pixel_y),
        .o_pixel_color (o_pix.pixel_color),
        .o_last_pixel  (o_pix.last_pixel)
    );

    assign i_cmd.ready = in_ready;
    assign o_pix.valid = out_valid;

endmodule

FILE: rtl/lpg_divider.sv
// ----------------------------------------------------------------------------
// Line pixel generator slope divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lpg_divider (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [lpg_pkg::DIV_BITS-1:0]    i_dividend,
    input  logic [lpg_pkg::COORD_BITS-1:0]  i_divisor,
    output logic                            o_done,
    output logic [lpg_pkg::DIV_BITS-1:0]    o_quotient
);

    logic                                r_busy;
    logic                                n_busy;
    logic                                r_done;
    logic                                n_done;
    logic [lpg_pkg::DIV_CNT_BITS-1:0]    r_count;
    logic [lpg_pkg::DIV_CNT_BITS-1:0]    n_count;
    logic [lpg_pkg::COORD_BITS-1:0]      r_rem;
    logic [lpg_pkg::COORD_BITS-1:0]      n_rem;
    logic [lpg_pkg::DIV_BITS-1:0]        r_quo;
    logic [lpg_pkg::DIV_BITS-1:0]        n_quo;
    logic [lpg_pkg::COORD_BITS-1:0]      r_div;
    logic [lpg_pkg::COORD_BITS-1:0]      n_div;

    logic [lpg_pkg::COORD_BITS:0]        trial;
    logic [lpg_pkg::COORD_BITS:0]        diff;
    logic                                ge;

    assign trial = {r_rem, r_quo[lpg_pkg::DIV_BITS-1]};
    assign ge    = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_count = r_count;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_div   = r_div;
        if (i_start) begin
            n_busy  = 1'b1;
            n_count = '0;
            n_rem   = '0;
            n_quo   = i_dividend;
            n_div   = i_divisor;
        end else if (r_busy) begin
            n_rem   = ge ? diff[lpg_pkg::COORD_BITS-1:0] : trial[lpg_pkg::COORD_BITS-1:0];
            n_quo   = {r_quo[lpg_pkg::DIV_BITS-2:0], ge};
            n_count = r_count + 1'b1;
            if (r_count == lpg_pkg::DIV_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_count <= n_count;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: rtl/lpg_datapath.sv
// ----------------------------------------------------------------------------
// Line pixel generator datapath
// Line setup, slope divider, major/minor stepping and the pixel output register.
// ----------------------------------------------------------------------------
module lpg_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lpg_pkg::t_lpg_ctrl              i_ctrl,
    output lpg_pkg::t_lpg_status            o_status,
    input  logic [lpg_pkg::COORD_BITS-1:0]  i_x_start,
    input  logic [lpg_pkg::COORD_BITS-1:0]  i_y_start,
    input  logic [lpg_pkg::COORD_BITS-1:0]  i_x_end,
    input  logic [lpg_pkg::COORD_BITS-1:0]  i_y_end,
    input  logic [lpg_pkg::COLOR_BITS-1:0]  i_line_color,
    output logic [lpg_pkg::COORD_BITS-1:0]  o_pixel_x,
    output logic [lpg_pkg::COORD_BITS-1:0]  o_pixel_y,
    output logic [lpg_pkg::COLOR_BITS-1:0]  o_pixel_color,
    output logic                            o_last_pixel
);

    logic signed [lpg_pkg::COORD_BITS:0]  dx;
    logic signed [lpg_pkg::COORD_BITS:0]  dy;
    logic [lpg_pkg::COORD_BITS:0]         dx_neg;
    logic [lpg_pkg::COORD_BITS:0]         dy_neg;
    logic [lpg_pkg::COORD_BITS-1:0]       adx;
    logic [lpg_pkg::COORD_BITS-1:0]       ady;
    logic                                 y_major;
    logic [lpg_pkg::COORD_BITS-1:0]       amin;
    logic [lpg_pkg::COORD_BITS-1:0]       amaj;
    logic [lpg_pkg::COORD_BITS-1:0]       maj_start;
    logic [lpg_pkg::COORD_BITS-1:0]       maj_end;
    logic [lpg_pkg::COORD_BITS-1:0]       min_start;
    logic                                 min_neg;
    logic                                 div_done;
    logic [lpg_pkg::DIV_BITS-1:0]         quotient;
    logic [lpg_pkg::ACC_BITS-1:0]         quo_ext;
    logic [lpg_pkg::COORD_BITS-1:0]       minor_pix;
    logic                                 last;

    logic                                 r_y_major;
    logic                                 r_step_down;
    logic                                 r_min_neg;
    logic                                 r_zero_major;
    logic [lpg_pkg::COORD_BITS-1:0]       r_pos;
    logic [lpg_pkg::COORD_BITS-1:0]       r_end;
    logic [lpg_pkg::ACC_BITS-1:0]         r_acc;
    logic [lpg_pkg::ACC_BITS-1:0]         r_inc;
    logic [lpg_pkg::COLOR_BITS-1:0]       r_color;
    logic [lpg_pkg::COORD_BITS-1:0]       r_pixel_x;
    logic [lpg_pkg::COORD_BITS-1:0]       r_pixel_y;
    logic [lpg_pkg::COLOR_BITS-1:0]       r_pixel_color;
    logic                                 r_last_pixel;

    assign dx     = $signed({1'b0, i_x_end}) - $signed({1'b0, i_x_start});
    assign dy     = $signed({1'b0, i_y_end}) - $signed({1'b0, i_y_start});
    assign dx_neg = -dx;
    assign dy_neg = -dy;
    assign adx    = dx[lpg_pkg::COORD_BITS] ? dx_neg[lpg_pkg::COORD_BITS-1:0]
                                            : dx[lpg_pkg::COORD_BITS-1:0];
    assign ady    = dy[lpg_pkg::COORD_BITS] ? dy_neg[lpg_pkg::COORD_BITS-1:0]
                                            : dy[lpg_pkg::COORD_BITS-1:0];
    assign y_major = ady > adx;

    always_comb begin
        if (y_major) begin
            amaj      = ady;
            amin      = adx;
            maj_start = i_y_start;
            maj_end   = i_y_end;
            min_start = i_x_start;
            min_neg   = dx[lpg_pkg::COORD_BITS];
        end else begin
            amaj      = adx;
            amin      = ady;
            maj_start = i_x_start;
            maj_end   = i_x_end;
            min_start = i_y_start;
            min_neg   = dy[lpg_pkg::COORD_BITS];
        end
    end

    lpg_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_ctrl.load_line),
        .i_dividend ({amin, lpg_pkg::FRAC_BITS'(0)}),
        .i_divisor  (amaj),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    assign quo_ext   = r_zero_major ? '0 : lpg_pkg::ACC_BITS'(quotient);
    assign minor_pix = r_acc[lpg_pkg::FRAC_BITS +: lpg_pkg::COORD_BITS];
    assign last      = r_pos == r_end;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_line) begin
            r_y_major    <= y_major;
            r_step_down  <= maj_end <= maj_start;
            r_min_neg    <= min_neg;
            r_zero_major <= amaj == '0;
            r_pos        <= maj_start;
            r_end        <= maj_end;
            r_acc        <= lpg_pkg::ACC_BITS'({min_start, lpg_pkg::HALF_ONE});
            r_color      <= i_line_color;
        end else if (i_ctrl.step) begin
            if (!last) begin
                r_pos <= r_step_down ? r_pos - 1'b1 : r_pos + 1'b1;
                r_acc <= r_acc + r_inc;
            end
        end
        if (div_done) begin
            r_inc <= r_min_neg ? -quo_ext : quo_ext;
        end
        if (i_ctrl.step) begin
            r_pixel_x     <= r_y_major ? minor_pix : r_pos;
            r_pixel_y     <= r_y_major ? r_pos : minor_pix;
            r_pixel_color <= r_color;
            r_last_pixel  <= last;
        end
    end

    assign o_status.div_done = div_done;
    assign o_status.last     = last;
    assign o_pixel_x         = r_pixel_x;
    assign o_pixel_y         = r_pixel_y;
    assign o_pixel_color     = r_pixel_color;
    assign o_last_pixel      = r_last_pixel;

endmodule

FILE: rtl/lpg_ctrl.sv
// ----------------------------------------------------------------------------
// Line pixel generator controller
// Sequences line setup, slope division and pixel stepping; owns output valid.
// ----------------------------------------------------------------------------
`include "line_pixel_generator_core_assert.svh"

module lpg_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_cmd,
    input  logic                  i_out_ready,
    input  lpg_pkg::t_lpg_status  i_status,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    output lpg_pkg::t_lpg_ctrl    o_ctrl
);

    lpg_pkg::t_lpg_state  r_state;
    lpg_pkg::t_lpg_state  n_state;
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic                 in_ready;
    logic                 start_fire;
    logic                 step_fire;

    always_comb begin
        in_ready    = (r_state != lpg_pkg::ST_DIVIDE) && (!r_out_valid || i_out_ready);
        start_fire  = i_in_valid && in_ready && (i_in_cmd == lpg_pkg::CMD_START);
        step_fire   = i_in_valid && in_ready && (i_in_cmd == lpg_pkg::CMD_STEP)
                      && (r_state == lpg_pkg::ST_ACTIVE);
        n_out_valid = step_fire ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lpg_pkg::ST_IDLE: begin
                if (start_fire) begin
                    n_state = lpg_pkg::ST_DIVIDE;
                end
            end
            lpg_pkg::ST_DIVIDE: begin
                if (i_status.div_done) begin
                    n_state = lpg_pkg::ST_ACTIVE;
                end
            end
            lpg_pkg::ST_ACTIVE: begin
                if (start_fire) begin
                    n_state = lpg_pkg::ST_DIVIDE;
                end else if (step_fire && i_status.last) begin
                    n_state = lpg_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lpg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lpg_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready       = in_ready;
    assign o_out_valid      = r_out_valid;
    assign o_ctrl.load_line = start_fire;
    assign o_ctrl.step      = step_fire;

    `LPG_ASSERT_IMPLY(a_done_only_dividing, i_clk, i_rst_n, i_status.div_done,
                      r_state == lpg_pkg::ST_DIVIDE)
    `LPG_ASSERT_IMPLY(a_step_has_room, i_clk, i_rst_n, o_ctrl.step,
                      !r_out_valid || i_out_ready)
    `LPG_ASSERT_NEXT(a_last_ends_line, i_clk, i_rst_n, step_fire && i_status.last,
                     r_state == lpg_pkg::ST_IDLE && r_out_valid)

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line pixel generator testbench
// Feeds line start and step commands with random gaps and long stalls on both
// channels, rasterizes each accepted command in a local 48.16 line tracer and
// compares every emitted pixel, in order, with the traced one.
// ----------------------------------------------------------------------------
module tb;

    localparam int COORD_MAX     = (1 << lpg_pkg::COORD_BITS) - 1;
    localparam int COLOR_MAX     = (1 << lpg_pkg::COLOR_BITS) - 1;
    localparam int RANDOM_ITEMS  = 500;
    localparam int HOLDOFF_AT    = 100;
    localparam int HOLDOFF_LEN   = 300;
    localparam int SETTLE_CYCLES = 60;
    localparam int STALL_LIMIT   = 4000;

    typedef struct {
        logic                           cmd;
        logic [lpg_pkg::COORD_BITS-1:0] x_start;
        logic [lpg_pkg::COORD_BITS-1:0] y_start;
        logic [lpg_pkg::COORD_BITS-1:0] x_end;
        logic [lpg_pkg::COORD_BITS-1:0] y_end;
        logic [lpg_pkg::COLOR_BITS-1:0] line_color;
        bit                             drain_first;
    } t_line_cmd;

    typedef struct {
        logic [lpg_pkg::COORD_BITS-1:0] pixel_x;
        logic [lpg_pkg::COORD_BITS-1:0] pixel_y;
        logic [lpg_pkg::COLOR_BITS-1:0] pixel_color;
        logic                           last_pixel;
    } t_pixel;

    logic i_clk;
    logic i_rst_n;

    lpg_cmd_if cmd_bus ();
    lpg_pix_if pix_bus ();

    line_pixel_generator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_pix   (pix_bus)
    );

    t_line_cmd command_q[$];
    t_pixel    pixel_q[$];
    t_line_cmd cur_cmd;
    int        mismatch_count;
    int        items_queued;
    int        pixels_seen;

    // line tracer state
    bit                             ln_active;
    bit                             ln_y_major;
    bit                             ln_down;
    logic [lpg_pkg::COORD_BITS-1:0] ln_pos;
    logic [lpg_pkg::COORD_BITS-1:0] ln_end;
    longint                         ln_acc;
    longint                         ln_inc;
    logic [lpg_pkg::COLOR_BITS-1:0] ln_color;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned pick_gap(inout int unsigned burst);
        int unsigned r;
        if (burst != 0) begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic rasterize_command(input t_line_cmd c);
        longint                         dx, dy, adx, ady;
        longint                         maj_d, min_d, amaj, amin;
        longint                         maj_start, min_start, slope;
        logic [lpg_pkg::COORD_BITS-1:0] minor;
        t_pixel                         p;
        if (c.cmd == lpg_pkg::CMD_START) begin
            dx  = longint'(c.x_end) - longint'(c.x_start);
            dy  = longint'(c.y_end) - longint'(c.y_start);
            adx = dx < 0 ? -dx : dx;
            ady = dy < 0 ? -dy : dy;
            ln_y_major = ady > adx;
            if (ln_y_major) begin
                maj_d = dy; min_d = dx; amaj = ady; amin = adx;
                maj_start = longint'(c.y_start);
                min_start = longint'(c.x_start);
            end else begin
                maj_d = dx; min_d = dy; amaj = adx; amin = ady;
                maj_start = longint'(c.x_start);
                min_start = longint'(c.y_start);
            end
            if (amaj == 0) begin
                slope = 0;
            end else begin
                slope = (amin <<< lpg_pkg::FRAC_BITS) / amaj;
                if ((min_d < 0) != (maj_d < 0)) slope = -slope;
            end
            ln_down   = !(maj_d > 0);
            ln_inc    = ln_down ? -slope : slope;
            ln_pos    = lpg_pkg::COORD_BITS'(maj_start);
            ln_end    = lpg_pkg::COORD_BITS'(maj_start + maj_d);
            ln_acc    = longint'(lpg_pkg::HALF_ONE) + (min_start <<< lpg_pkg::FRAC_BITS);
            ln_color  = c.line_color;
            ln_active = 1'b1;
        end else if (ln_active) begin
            minor         = lpg_pkg::COORD_BITS'(ln_acc >>> lpg_pkg::FRAC_BITS);
            p.last_pixel  = ln_pos == ln_end;
            p.pixel_x     = ln_y_major ? minor : ln_pos;
            p.pixel_y     = ln_y_major ? ln_pos : minor;
            p.pixel_color = ln_color;
            pixel_q.push_back(p);
            if (p.last_pixel) begin
                ln_active = 1'b0;
            end else begin
                ln_pos = ln_down ? ln_pos - 1'b1 : ln_pos + 1'b1;
                ln_acc = ln_acc + ln_inc;
            end
        end
    endtask

    task automatic queue_start(input int xs, input int ys, input int xe, input int ye,
                               input int color, input bit drain);
        t_line_cmd c;
        c.cmd         = lpg_pkg::CMD_START;
        c.x_start     = lpg_pkg::COORD_BITS'(xs);
        c.y_start     = lpg_pkg::COORD_BITS'(ys);
        c.x_end       = lpg_pkg::COORD_BITS'(xe);
        c.y_end       = lpg_pkg::COORD_BITS'(ye);
        c.line_color  = lpg_pkg::COLOR_BITS'(color);
        c.drain_first = drain;
        command_q.push_back(c);
        items_queued++;
    endtask

    // payload of a step is don't-care; randomize it
    task automatic queue_random(input logic cmd);
        t_line_cmd c;
        c.cmd         = cmd;
        c.x_start     = lpg_pkg::COORD_BITS'($urandom_range(0, COORD_MAX));
        c.y_start     = lpg_pkg::COORD_BITS'($urandom_range(0, COORD_MAX));
        c.x_end       = lpg_pkg::COORD_BITS'($urandom_range(0, COORD_MAX));
        c.y_end       = lpg_pkg::COORD_BITS'($urandom_range(0, COORD_MAX));
        c.line_color  = lpg_pkg::COLOR_BITS'($urandom_range(0, COLOR_MAX));
        c.drain_first = 1'b0;
        command_q.push_back(c);
    endtask

    task automatic queue_steps(input int count);
        repeat (count) begin
            queue_random(lpg_pkg::CMD_STEP);
            items_queued++;
        end
    endtask

    function automatic int near_coord(input int base, input int span);
        int off;
        int v;
        off = $urandom_range(0, span);
        if ($urandom_range(0, 1) != 0) off = -off;
        v = base + off;
        if (v < 0 || v > COORD_MAX) v = base - off;
        return v;
    endfunction

    // command driver
    int unsigned send_gap;
    int unsigned send_burst;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_bus.valid <= 1'b0;
            send_gap   = 0;
            send_burst = 0;
        end else begin
            if (cmd_bus.valid && cmd_bus.ready) begin
                rasterize_command(cur_cmd);
                send_gap = pick_gap(send_burst);
            end
            if (cmd_bus.valid && !cmd_bus.ready) begin
                // hold the offered transaction
            end else if (send_gap != 0) begin
                send_gap--;
                cmd_bus.valid <= 1'b0;
            end else if (command_q.size() != 0 &&
                         !(command_q[0].drain_first && pixel_q.size() != 0)) begin
                cur_cmd = command_q.pop_front();
                cmd_bus.valid      <= 1'b1;
                cmd_bus.cmd        <= cur_cmd.cmd;
                cmd_bus.x_start    <= cur_cmd.x_start;
                cmd_bus.y_start    <= cur_cmd.y_start;
                cmd_bus.x_end      <= cur_cmd.x_end;
                cmd_bus.y_end      <= cur_cmd.y_end;
                cmd_bus.line_color <= cur_cmd.line_color;
            end else begin
                cmd_bus.valid <= 1'b0;
            end
        end
    end

    // pixel monitor
    int unsigned recv_gap;
    int unsigned recv_burst;
    int unsigned hold_cycles;
    bit          holdoff_done;

    always @(posedge i_clk) begin
        t_pixel exp_pix;
        if (!i_rst_n) begin
            pix_bus.ready <= 1'b0;
            recv_gap     = 0;
            recv_burst   = 0;
            hold_cycles  = 0;
            holdoff_done = 1'b0;
        end else begin
            if (pix_bus.valid && pix_bus.ready) begin
                pixels_seen++;
                recv_gap = pick_gap(recv_burst);
                if (pixel_q.size() == 0) begin
                    $display("%0t: unexpected pixel x=%0d y=%0d color=%0h last=%0b",
                             $time, pix_bus.pixel_x, pix_bus.pixel_y,
                             pix_bus.pixel_color, pix_bus.last_pixel);
                    mismatch_count++;
                end else begin
                    exp_pix = pixel_q.pop_front();
                    if (pix_bus.pixel_x !== exp_pix.pixel_x) begin
                        $display("%0t: pixel_x expected %0d actual %0d",
                                 $time, exp_pix.pixel_x, pix_bus.pixel_x);
                        mismatch_count++;
                    end
                    if (pix_bus.pixel_y !== exp_pix.pixel_y) begin
                        $display("%0t: pixel_y expected %0d actual %0d",
                                 $time, exp_pix.pixel_y, pix_bus.pixel_y);
                        mismatch_count++;
                    end
                    if (pix_bus.pixel_color !== exp_pix.pixel_color) begin
                        $display("%0t: pixel_color expected %0h actual %0h",
                                 $time, exp_pix.pixel_color, pix_bus.pixel_color);
                        mismatch_count++;
                    end
                    if (pix_bus.last_pixel !== exp_pix.last_pixel) begin
                        $display("%0t: last_pixel expected %0b actual %0b",
                                 $time, exp_pix.last_pixel, pix_bus.last_pixel);
                        mismatch_count++;
                    end
                end
            end
            if (!holdoff_done && pixels_seen >= HOLDOFF_AT) begin
                holdoff_done = 1'b1;
                hold_cycles  = HOLDOFF_LEN;
            end
            if (hold_cycles != 0) begin
                hold_cycles--;
                pix_bus.ready <= 1'b0;
            end else if (recv_gap != 0) begin
                recv_gap--;
                pix_bus.ready <= 1'b0;
            end else begin
                pix_bus.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transaction
    int unsigned quiet_cycles;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            if ((cmd_bus.valid && cmd_bus.ready) || (pix_bus.valid && pix_bus.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        int  xs, ys, xe, ye;
        int  span, len, steps, pick, tail;
        bit  first_line;

        i_rst_n            = 1'b0;
        cmd_bus.valid      = 1'b0;
        cmd_bus.cmd        = lpg_pkg::CMD_START;
        cmd_bus.x_start    = '0;
        cmd_bus.y_start    = '0;
        cmd_bus.x_end      = '0;
        cmd_bus.y_end      = '0;
        cmd_bus.line_color = '0;
        pix_bus.ready      = 1'b0;
        mismatch_count     = 0;
        items_queued       = 0;
        pixels_seen        = 0;
        ln_active          = 1'b0;
        ln_y_major         = 1'b0;
        ln_down            = 1'b0;
        ln_pos             = '0;
        ln_end             = '0;
        ln_acc             = 0;
        ln_inc             = 0;
        ln_color           = '0;

        // step while idle
        queue_steps(1);
        // single-pixel line, then a step with no line
        queue_start(5, 5, 5, 5, COLOR_MAX, 1'b0);
        queue_steps(2);
        // full diagonal, replaced before its end
        queue_start(0, 0, COORD_MAX, COORD_MAX, 0, 1'b0);
        queue_steps(3);
        // tie with x stepping down and y going up
        queue_start(COORD_MAX, 0, 0, COORD_MAX, 16'h5a5a, 1'b0);
        queue_steps(2);
        // steep line, y major stepping down
        queue_start(3, 6, 5, 2, 16'h1234, 1'b0);
        queue_steps(5);
        // horizontal, x stepping down
        queue_start(6, 7, 2, 7, 16'h8001, 1'b0);
        queue_steps(5);
        // vertical, y stepping down, near the far corner
        queue_start(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX - 4, 16'hedcb, 1'b0);
        queue_steps(5);

        first_line   = 1'b1;
        items_queued = 0;
        while (items_queued < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                repeat ($urandom_range(1, 3)) queue_random(logic'($urandom_range(0, 1)));
            end else begin
                xs = $urandom_range(0, COORD_MAX);
                ys = $urandom_range(0, COORD_MAX);
                if (pick < 80) span = 12;
                else if (pick < 96) span = 100;
                else span = COORD_MAX;
                if (span == COORD_MAX) begin
                    xe = $urandom_range(0, COORD_MAX);
                    ye = $urandom_range(0, COORD_MAX);
                end else begin
                    xe = near_coord(xs, span);
                    ye = near_coord(ys, span);
                end
                len = (xe > xs) ? xe - xs : xs - xe;
                if (((ye > ys) ? ye - ys : ys - ye) > len) len = (ye > ys) ? ye - ys : ys - ye;
                queue_start(xs, ys, xe, ye, $urandom_range(0, COLOR_MAX),
                            first_line || ($urandom_range(0, 99) < 4));
                first_line = 1'b0;
                tail = $urandom_range(0, 9);
                if (tail == 0) steps = $urandom_range(0, len);
                else if (tail == 1) steps = len + 1 + $urandom_range(1, 3);
                else steps = len + 1;
                if (steps > RANDOM_ITEMS - items_queued) steps = RANDOM_ITEMS - items_queued;
                queue_steps(steps);
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (command_q.size() != 0 || cmd_bus.valid || pixel_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pixel_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/lpg_pkg.sv
rtl/lpg_if.sv
rtl/lpg_divider.sv
rtl/lpg_datapath.sv
rtl/lpg_ctrl.sv
rtl/line_pixel_generator_core.sv
dv/tb.sv
